[src/rgch_pkg.sv]
// shared types and constants for the rg chromaticity histogram
package rgch_pkg;

  localparam int CFG_W           = 5;
  localparam int OP_W            = 2;
  localparam int CHAN_W          = 8;
  localparam int IDX_W           = 8;
  localparam int FIELD_W         = 24;
  localparam int SHARE_W         = 17;
  localparam int STAT_W          = 2;
  localparam int QW              = 17;
  localparam int STEP_W          = 5;
  localparam int SUM_W           = 10;
  localparam int DEF_MAX_BINS    = 16;
  localparam int DEF_COUNT_WIDTH = 24;

  localparam logic [CFG_W-1:0]   BINS_RESET = 5'd16;
  localparam logic [SHARE_W-1:0] SHARE_FULL = 17'h10000;
  localparam logic [FIELD_W-1:0] FIELD_MAX  = 24'hFFFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_R,
    ST_DIV_G,
    ST_RD_PIX,
    ST_RD_BIN,
    ST_SHARE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

[src/rgch_if.sv]
// valid/ready channel interfaces for pixel ops and read results
interface rgch_pix_if;
  import rgch_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [IDX_W-1:0]  bin_index;

  modport source (output valid, op, red, green, blue, bin_index, input ready);
  modport sink (input valid, op, red, green, blue, bin_index, output ready);
endinterface

interface rgch_res_if;
  import rgch_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] bin_count;
  logic [SHARE_W-1:0] share;
  logic [FIELD_W-1:0] valid_total;
  logic [STAT_W-1:0]  status;

  modport source (output valid, bin_count, share, valid_total, status, input ready);
  modport sink (input valid, bin_count, share, valid_total, status, output ready);
endinterface

[src/rgch_div.sv]
// shared restoring divider, one quotient bit per cycle
module rgch_div #(
  parameter int DEN_W = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rgch_pkg::div_req_t          req_i,
  input  logic [DEN_W-1:0]            rem0_i,
  input  logic [rgch_pkg::QW-1:0]     low_i,
  input  logic [DEN_W-1:0]            den_i,
  output logic                        done_o,
  output logic [rgch_pkg::QW-1:0]     quo_o
);
  import rgch_pkg::*;

  logic              run_q, run_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [QW-1:0]     low_q;
  logic [QW-1:0]     quo_q;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;
  logic              busy;

  assign busy   = run_q && (step_q != '0);
  assign done_o = run_q && (step_q == '0);
  assign quo_o  = quo_q;
  assign trial  = {rem_q, low_q[QW-1]};
  assign diff   = trial - {1'b0, den_q};
  assign fits   = trial >= {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    if (req_i.start) begin
      run_d  = 1'b1;
      step_d = req_i.steps;
    end else if (busy) begin
      step_d = step_q - 1'b1;
    end else if (done_o) begin
      run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= rem0_i;
      low_q <= low_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy) begin
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

endmodule

[src/rg_chromaticity_histogram.sv]
// rg chromaticity 2d histogram: bin finder, bin store and share divider
//
//   channel | dir | handshake     | payload
//   pix_i   | in  | valid / ready | op, red, green, blue, bin_index
//   res_o   | out | valid / ready | bin_count, share, valid_total, status
//   cfg     | in  | cfg_we_i      | cfg_wdata_i (bins per axis)
//
// clear, unused op and black pixel: handled in ST_IDLE without leaving it
// pixel: red and green bins from the shared divider, then a bin store read and write
// read: bin store read, then a 17-bit share quotient from the divider; an index out of range skips both
// reset clears the bin valid bits and the total at once; a full result register
// holds a finished read until res_o.ready, new transactions are still accepted but a further read waits in ST_OUT
module rg_chromaticity_histogram #(
  parameter int MAX_BINS    = rgch_pkg::DEF_MAX_BINS,
  parameter int COUNT_WIDTH = rgch_pkg::DEF_COUNT_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rgch_pkg::CFG_W-1:0] cfg_wdata_i,
  rgch_pix_if.sink                   pix_i,
  rgch_res_if.source                 res_o
);
  import rgch_pkg::*;

  localparam int DEPTH = MAX_BINS * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(MAX_BINS);
  localparam int NB_W  = $clog2(MAX_BINS + 1);
  localparam int SQ_W  = $clog2(DEPTH + 1);
  localparam int CMP_W = (SQ_W > IDX_W) ? SQ_W : IDX_W;
  localparam int DEN_W = (COUNT_WIDTH > SUM_W) ? COUNT_WIDTH : SUM_W;
  localparam int MUL_W = CHAN_W + NB_W;
  localparam int EXT_W = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

  state_e state_q, state_d;

  logic [CFG_W-1:0]       bins_q;
  logic [NB_W-1:0]        b_eff;
  logic [SQ_W-1:0]        b_sq;

  logic [COUNT_WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]       valid_q;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   rdv_q;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [AW-1:0]          raddr;
  logic                   mem_we;
  logic [COUNT_WIDTH-1:0] wdata;
  logic                   clr;

  logic [COUNT_WIDTH-1:0] total_q;
  logic                   total_inc;

  logic [CHAN_W-1:0]      green_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SUM_W-1:0]       sum_in;
  logic [BW-1:0]          rb_q;
  logic [AW-1:0]          slot_q;
  logic [AW:0]            slot_full;
  logic                   rb_ld;
  logic                   pix_ld;
  logic                   slot_ld;

  div_req_t               div_req;
  logic                   share_mode;
  logic [CHAN_W-1:0]      div_chan;
  logic [DEN_W-1:0]       div_den;
  logic [MUL_W-1:0]       prod;
  logic [DEN_W-1:0]       div_rem0;
  logic [QW-1:0]          div_low;
  logic                   div_done;
  logic [QW-1:0]          quo;
  logic [NB_W-1:0]        q_bin;
  logic [BW-1:0]          bin_cl;

  logic                   res_ld;
  logic                   share_ld;
  logic [COUNT_WIDTH-1:0] res_cnt_d, res_cnt_q;
  status_e                res_stat_d, res_stat_q;
  logic [SHARE_W-1:0]     res_share_q;
  logic [SHARE_W-1:0]     share_cl;

  logic                   out_ld;
  logic                   out_valid_q;
  logic [EXT_W-1:0]       cnt_ext;
  logic [EXT_W-1:0]       tot_ext;
  logic [FIELD_W-1:0]     out_cnt_q, out_tot_q;
  logic [SHARE_W-1:0]     out_share_q;
  logic [STAT_W-1:0]      out_stat_q;

  logic [CMP_W-1:0]       idx_ext;
  logic [CMP_W-1:0]       bsq_ext;

  // effective bins per axis
  always_comb begin
    if (bins_q < 5'd2) begin
      b_eff = NB_W'(2);
    end else if (bins_q > CFG_W'(MAX_BINS)) begin
      b_eff = NB_W'(MAX_BINS);
    end else begin
      b_eff = bins_q[NB_W-1:0];
    end
  end

  assign b_sq    = SQ_W'(b_eff) * SQ_W'(b_eff);
  assign idx_ext = CMP_W'(pix_i.bin_index);
  assign bsq_ext = CMP_W'(b_sq);
  assign sum_in  = SUM_W'(pix_i.red) + SUM_W'(pix_i.green) + SUM_W'(pix_i.blue);
  assign rd_cnt  = rdv_q ? rd_q : '0;
  assign wdata   = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;

  // divider operands
  assign prod     = MUL_W'(div_chan) * MUL_W'(b_eff);
  assign div_rem0 = share_mode ? DEN_W'(rd_cnt >> 1) : DEN_W'(prod >> NB_W);
  assign div_low  = share_mode ? {rd_cnt[0], {(QW-1){1'b0}}}
                               : {prod[NB_W-1:0], {(QW-NB_W){1'b0}}};

  assign q_bin     = quo[NB_W-1:0];
  assign bin_cl    = (q_bin >= b_eff) ? BW'(b_eff - 1'b1) : BW'(q_bin);
  assign slot_full = (AW+1)'(bin_cl) * (AW+1)'(b_eff) + (AW+1)'(rb_q);
  assign share_cl  = (quo > QW'(SHARE_FULL)) ? SHARE_FULL : SHARE_W'(quo);

  rgch_div #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rem0_i (div_rem0),
    .low_i  (div_low),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    state_d     = state_q;
    pix_i.ready = 1'b0;
    div_req     = '0;
    share_mode  = 1'b0;
    div_chan    = pix_i.red;
    div_den     = DEN_W'(sum_in);
    raddr       = pix_i.bin_index[AW-1:0];
    mem_we      = 1'b0;
    clr         = 1'b0;
    total_inc   = 1'b0;
    pix_ld      = 1'b0;
    rb_ld       = 1'b0;
    slot_ld     = 1'b0;
    res_ld      = 1'b0;
    share_ld    = 1'b0;
    res_cnt_d   = '0;
    res_stat_d  = STAT_OK;
    out_ld      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pix_i.ready = 1'b1;
        if (pix_i.valid) begin
          case (pix_i.op)
            OP_CLEAR: begin
              clr = 1'b1;
            end
            OP_PIXEL: begin
              if (sum_in != '0) begin
                pix_ld        = 1'b1;
                div_req.start = 1'b1;
                div_req.steps = STEP_W'(NB_W);
                state_d       = ST_DIV_R;
              end
            end
            OP_READ: begin
              if (idx_ext >= bsq_ext) begin
                res_ld     = 1'b1;
                res_stat_d = STAT_RANGE;
                state_d    = ST_OUT;
              end else begin
                state_d = ST_RD_BIN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV_R: begin
        div_chan = green_q;
        div_den  = DEN_W'(sum_q);
        if (div_done) begin
          rb_ld         = 1'b1;
          div_req.start = 1'b1;
          div_req.steps = STEP_W'(NB_W);
          state_d       = ST_DIV_G;
        end
      end
      ST_DIV_G: begin
        raddr = slot_full[AW-1:0];
        if (div_done) begin
          slot_ld = 1'b1;
          state_d = ST_RD_PIX;
        end
      end
      ST_RD_PIX: begin
        mem_we    = 1'b1;
        total_inc = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_RD_BIN: begin
        share_mode = 1'b1;
        div_den    = DEN_W'(total_q);
        res_ld     = 1'b1;
        res_cnt_d  = rd_cnt;
        if (total_q == '0) begin
          res_stat_d = STAT_EMPTY;
          state_d    = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          div_req.steps = STEP_W'(QW);
          state_d       = ST_SHARE;
        end
      end
      ST_SHARE: begin
        if (div_done) begin
          share_ld = 1'b1;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || res_o.ready) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bins_q      <= BINS_RESET;
      total_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bins_q <= cfg_wdata_i;
      end
      if (clr) begin
        total_q <= '0;
        valid_q <= '0;
      end else begin
        if (total_inc && total_q != '1) begin
          total_q <= total_q + 1'b1;
        end
        if (mem_we) begin
          valid_q[slot_q] <= 1'b1;
        end
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // bin store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= wdata;
    end
    rd_q  <= mem_q[raddr];
    rdv_q <= valid_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pix_ld) begin
      green_q <= pix_i.green;
      sum_q   <= sum_in;
    end
    if (rb_ld) begin
      rb_q <= bin_cl;
    end
    if (slot_ld) begin
      slot_q <= slot_full[AW-1:0];
    end
    if (res_ld) begin
      res_cnt_q   <= res_cnt_d;
      res_stat_q  <= res_stat_d;
      res_share_q <= '0;
    end else if (share_ld) begin
      res_share_q <= share_cl;
    end
    if (out_ld) begin
      out_cnt_q   <= (cnt_ext > EXT_W'(FIELD_MAX)) ? FIELD_MAX : cnt_ext[FIELD_W-1:0];
      out_tot_q   <= (tot_ext > EXT_W'(FIELD_MAX)) ? FIELD_MAX : tot_ext[FIELD_W-1:0];
      out_share_q <= res_share_q;
      out_stat_q  <= res_stat_q;
    end
  end

  assign cnt_ext = EXT_W'(res_cnt_q);
  assign tot_ext = EXT_W'(total_q);

  assign res_o.valid       = out_valid_q;
  assign res_o.bin_count   = out_cnt_q;
  assign res_o.share       = out_share_q;
  assign res_o.valid_total = out_tot_q;
  assign res_o.status      = out_stat_q;

endmodule

[src/rgch_chk.sv]
// port-level checks on read results, bound to the top level
module rgch_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [rgch_pkg::FIELD_W-1:0] bin_count_i,
  input logic [rgch_pkg::SHARE_W-1:0] share_i,
  input logic [rgch_pkg::FIELD_W-1:0] valid_total_i,
  input logic [rgch_pkg::STAT_W-1:0]  status_i
);
  import rgch_pkg::*;

  // stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(bin_count_i)
      && $stable(share_i) && $stable(status_i))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_RANGE |-> bin_count_i == '0 && share_i == '0)
    else $error("out of range read carries data");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_EMPTY |->
      share_i == '0 && valid_total_i == '0 && bin_count_i == '0)
    else $error("empty histogram read carries data");

  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_OK |->
      valid_total_i != '0 && share_i <= SHARE_FULL && bin_count_i <= valid_total_i)
    else $error("share or count inconsistent with total");

endmodule

bind rg_chromaticity_histogram rgch_chk u_rgch_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .bin_count_i   (res_o.bin_count),
  .share_i       (res_o.share),
  .valid_total_i (res_o.valid_total),
  .status_i      (res_o.status)
);

[tb/rgch_checker.sv]
`timescale 1ns / 100ps
// checker that tracks the histogram, predicts every read result and compares it field by field
module rgch_checker #(
  parameter int MAX_BINS = rgch_pkg::DEF_MAX_BINS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rgch_pkg::CFG_W-1:0] cfg_wdata_i,
  rgch_pix_if                        pix_i,
  rgch_res_if                        res_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         checked_o
);
  import rgch_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] bin_count;
    logic [SHARE_W-1:0] share;
    logic [FIELD_W-1:0] valid_total;
    status_e            status;
  } bin_read_t;

  logic [FIELD_W-1:0] hist_q [MAX_BINS*MAX_BINS];
  logic [FIELD_W-1:0] total_q;
  logic [CFG_W-1:0]   bins_q;
  bin_read_t          bin_read_q [$];

  function automatic int unsigned axis_bins(logic [CFG_W-1:0] cfg);
    if (cfg < 2) return 2;
    if (cfg > MAX_BINS) return MAX_BINS;
    return int'(cfg);
  endfunction

  function automatic int unsigned chroma_bin(logic [CHAN_W-1:0] chan, int unsigned sum,
                                             int unsigned nb);
    int unsigned q;
    q = (int'(chan) * nb) / sum;
    return (q >= nb) ? nb - 1 : q;
  endfunction

  function automatic logic [FIELD_W-1:0] count_up(logic [FIELD_W-1:0] v);
    return (v == FIELD_MAX) ? v : v + 1'b1;
  endfunction

  function automatic bin_read_t predict_read(logic [IDX_W-1:0] idx);
    bin_read_t       r;
    longint unsigned q;
    int unsigned     nb;
    nb            = axis_bins(bins_q);
    r.bin_count   = '0;
    r.share       = '0;
    r.valid_total = total_q;
    if (idx >= nb * nb) begin
      r.status = STAT_RANGE;
    end else begin
      r.bin_count = hist_q[idx];
      if (total_q == '0) begin
        r.status = STAT_EMPTY;
      end else begin
        q = hist_q[idx];
        q = (q << 16) / total_q;
        if (q > SHARE_FULL) q = SHARE_FULL;
        r.share  = q[SHARE_W-1:0];
        r.status = STAT_OK;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bin_read_t   want;
    int unsigned nb, sum, slot;
    if (!rst_ni) begin
      foreach (hist_q[i]) hist_q[i] = '0;
      total_q   = '0;
      bins_q    = BINS_RESET;
      errors_o  = 0;
      checked_o = 0;
      bin_read_q.delete();
    end else begin
      if (cfg_we_i) bins_q = cfg_wdata_i;

      if (res_i.valid && res_i.ready) begin
        if (bin_read_q.size() == 0) begin
          $error("read result with no read pending");
          errors_o++;
        end else begin
          want = bin_read_q.pop_front();
          checked_o++;
          if (res_i.bin_count !== want.bin_count) begin
            $error("bin_count: expected %0d, got %0d", want.bin_count, res_i.bin_count);
            errors_o++;
          end
          if (res_i.share !== want.share) begin
            $error("share: expected %0d, got %0d", want.share, res_i.share);
            errors_o++;
          end
          if (res_i.valid_total !== want.valid_total) begin
            $error("valid_total: expected %0d, got %0d", want.valid_total, res_i.valid_total);
            errors_o++;
          end
          if (res_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_i.status);
            errors_o++;
          end
        end
      end

      if (pix_i.valid && pix_i.ready) begin
        case (pix_i.op)
          OP_CLEAR: begin
            foreach (hist_q[i]) hist_q[i] = '0;
            total_q = '0;
          end
          OP_PIXEL: begin
            sum = int'(pix_i.red) + int'(pix_i.green) + int'(pix_i.blue);
            if (sum != 0) begin
              nb   = axis_bins(bins_q);
              slot = chroma_bin(pix_i.green, sum, nb) * nb + chroma_bin(pix_i.red, sum, nb);
              hist_q[slot] = count_up(hist_q[slot]);
              total_q      = count_up(total_q);
            end
          end
          OP_READ: bin_read_q = {bin_read_q, predict_read(pix_i.bin_index)};
          default: ;
        endcase
      end
    end
    pending_o = bin_read_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// testbench top: clock, reset, pixel, read, clear and bin setting stimulus, result back-pressure and verdict
module tb;
  import rgch_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE     = 40;
  localparam int IDLE_LIMIT = 2000;
  localparam int PER_PHASE  = 38;
  localparam int N_PHASES   = 10;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  int errors, pending, checked;
  int n_pixel, n_read, n_clear, n_unused, n_cfg;
  int idle_cycles;
  bit steady;
  int unsigned ready_left;

  rgch_pix_if pix ();
  rgch_res_if res ();

  rg_chromaticity_histogram dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix),
    .res_o       (res)
  );

  rgch_checker hist_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix),
    .res_i       (res),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(8, 60);
  endfunction

  // result side back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready  <= 1'b0;
      ready_left <= 0;
    end else if (steady) begin
      res.ready <= 1'b1;
    end else if (ready_left == 0) begin
      res.ready  <= ~res.ready;
      ready_left <= idle_len();
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] red,
                           input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue,
                           input logic [IDX_W-1:0] idx);
    int unsigned gap;
    pix.valid     <= 1'b1;
    pix.op        <= op;
    pix.red       <= red;
    pix.green     <= green;
    pix.blue      <= blue;
    pix.bin_index <= idx;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    if (op == OP_PIXEL) n_pixel++;
    else if (op == OP_READ) n_read++;
    else if (op == OP_CLEAR) n_clear++;
    else n_unused++;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_bins(input logic [CFG_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic [CHAN_W-1:0] tone();
    if ($urandom_range(0, 1) == 0) return CHAN_W'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd2;
      3:       return 8'd127;
      4:       return 8'd128;
      default: return 8'd255;
    endcase
  endfunction

  task automatic random_item(input int unsigned span);
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] red, green, blue;
    logic [IDX_W-1:0]  idx;
    pick  = $urandom_range(0, 99);
    red   = tone();
    green = tone();
    blue  = tone();
    if ($urandom_range(0, 4) == 0) idx = IDX_W'($urandom_range(0, 255));
    else idx = IDX_W'($urandom_range(0, span * span - 1));
    if (pick < 58) begin
      op = OP_PIXEL;
    end else if (pick < 90) begin
      op = OP_READ;
    end else if (pick < 92) begin
      op = OP_CLEAR;
    end else if (pick < 95) begin
      op = OP_UNUSED;
    end else begin
      op    = OP_PIXEL;
      red   = '0;
      green = '0;
      blue  = '0;
    end
    send_item(op, red, green, blue, idx);
  endtask

  initial begin
    logic [CFG_W-1:0] settings [N_PHASES];
    int unsigned      span;
    settings = '{5'd2, 5'd0, 5'd31, 5'd16, 5'd1, 5'd17, 5'd3, 5'd7, 5'd0, 5'd16};
    settings[8] = CFG_W'($urandom_range(0, 31));

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    pix.valid     = 1'b0;
    pix.op        = OP_CLEAR;
    pix.red       = '0;
    pix.green     = '0;
    pix.blue      = '0;
    pix.bin_index = '0;
    steady        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset bin setting
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd255);
    send_item(OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(OP_PIXEL,  8'd0,   8'd0,   8'd0,   8'd0);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(OP_PIXEL,  8'd255, 8'd0,   8'd0,   8'd0);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd15);
    send_item(OP_PIXEL,  8'd0,   8'd255, 8'd0,   8'd0);
    send_item(OP_PIXEL,  8'd0,   8'd0,   8'd255, 8'd0);
    send_item(OP_PIXEL,  8'd255, 8'd255, 8'd255, 8'd0);
    send_item(OP_PIXEL,  8'd1,   8'd1,   8'd1,   8'd0);
    send_item(OP_PIXEL,  8'd255, 8'd255, 8'd0,   8'd0);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd15);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd240);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd85);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd136);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd255);
    send_item(OP_CLEAR,  8'd255, 8'd255, 8'd255, 8'd255);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd85);
    send_item(OP_PIXEL,  8'd128, 8'd64,  8'd32,  8'd0);
    send_item(OP_READ,   8'd0,   8'd0,   8'd0,   8'd73);

    // random phases, bins changed with and without a clear
    foreach (settings[p]) begin
      write_bins(settings[p]);
      span   = (settings[p] < 2) ? 2 : (settings[p] > 16) ? 16 : settings[p];
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) send_item(OP_CLEAR, '0, '0, '0, '0);
      repeat (PER_PHASE) random_item(span);
      steady = 1'b0;
    end

    drain();
    $display("ran %0d pixel, %0d read, %0d clear and %0d unused-op transactions",
             n_pixel, n_read, n_clear, n_unused);
    $display("over %0d bin settings, %0d read results checked", n_cfg, checked);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
src/rgch_pkg.sv
src/rgch_if.sv
src/rgch_div.sv
src/rg_chromaticity_histogram.sv
src/rgch_chk.sv
tb/rgch_checker.sv
tb/tb.sv
